>>> src/itad_pkg.sv
// Package for the integer to ASCII text converter.
// Holds the mode codes, character constants, digit geometry, the glyph function
// and the command and status types shared by the controller and the datapath.
package itad_pkg;

	localparam logic MODE_DEC = 1'b0;
	localparam logic MODE_HEX = 1'b1;

	localparam int WORD_W = 32;
	localparam int CHAR_W = 8;
	localparam int NUM_DIG = 10;
	localparam int DIG_W = $clog2(NUM_DIG);
	localparam int HEX_NIB = WORD_W / 4;
	localparam int CNT_W = $clog2(WORD_W);

	localparam logic [CHAR_W-1:0] MINUS_CODE = 8'h2d;
	localparam logic [CHAR_W-1:0] ZERO_CODE = 8'h30;
	localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'h57;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic set_idx;
		logic emit;
	} itad_ctl_t;

	typedef struct packed {
		logic conv_done;
		logic last;
	} itad_sts_t;

	function automatic logic [CHAR_W-1:0] glyph(input digit_t d);
		logic [CHAR_W-1:0] ext;
		ext = {4'b0000, d};
		if (d < 4'd10) begin
			return ZERO_CODE + ext;
		end
		return ALPHA_BASE + ext;
	endfunction

endpackage

>>> src/itad_if.sv
// Channel interfaces for the integer to ASCII text converter.
// The input channel carries a mode and a word, the output channel one character.
// Depends on nothing.
interface itad_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [31:0] value;

	modport source(output valid, output cmd, output value, input ready);
	modport sink(input valid, input cmd, input value, output ready);
endinterface

interface itad_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

>>> src/itad_dp.sv
// Datapath of the integer to ASCII text converter.
// Holds the binary-to-BCD shift register, the digit index and the output register.
// Depends on itad_pkg.
module itad_dp #(
	parameter int HEX_DIGITS = 8,
	parameter int IDX_W = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  itad_pkg::itad_ctl_t                ctl,
	output itad_pkg::itad_sts_t                sts,
	input  logic                               in_cmd,
	input  logic [itad_pkg::WORD_W-1:0]        in_value,
	output logic [itad_pkg::CHAR_W-1:0]        char_code,
	output logic                               last
);
	import itad_pkg::*;

	digit_t             dig_q [NUM_DIG];
	digit_t             adj [NUM_DIG];
	logic [WORD_W-1:0]  bin_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   msd;
	logic [IDX_W-1:0]   start_idx;
	logic               sign_q;
	logic               hex_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic               neg;
	logic [WORD_W-1:0]  mag;
	digit_t             cur;

	assign neg = (in_cmd == MODE_DEC) && in_value[WORD_W-1];
	assign mag = neg ? (~in_value + WORD_W'(1)) : in_value;

	always_comb begin
		for (int i = 0; i < NUM_DIG; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? (dig_q[i] + 4'd3) : dig_q[i];
		end
	end

	always_comb begin
		msd = '0;
		for (int i = 0; i < NUM_DIG; i++) begin
			if (dig_q[i] != 4'd0) begin
				msd = IDX_W'(i);
			end
		end
		start_idx = msd;
		if (hex_q == MODE_HEX && msd < IDX_W'(HEX_DIGITS - 1)) begin
			start_idx = IDX_W'(HEX_DIGITS - 1);
		end
	end

	assign cur = (idx_q < IDX_W'(NUM_DIG)) ? dig_q[idx_q[DIG_W-1:0]] : 4'd0;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < HEX_NIB; i++) begin
				dig_q[i] <= (in_cmd == MODE_HEX) ? in_value[4*i +: 4] : 4'd0;
			end
			for (int i = HEX_NIB; i < NUM_DIG; i++) begin
				dig_q[i] <= 4'd0;
			end
			bin_q <= mag;
			cnt_q <= '0;
			hex_q <= in_cmd;
		end else if (ctl.shift) begin
			dig_q[0] <= {adj[0][2:0], bin_q[WORD_W-1]};
			for (int i = 1; i < NUM_DIG; i++) begin
				dig_q[i] <= {adj[i][2:0], adj[i-1][3]};
			end
			bin_q <= {bin_q[WORD_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (ctl.set_idx) begin
			idx_q <= start_idx;
		end
		if (ctl.emit) begin
			if (sign_q) begin
				char_q <= MINUS_CODE;
				last_q <= 1'b0;
			end else begin
				char_q <= glyph(cur);
				last_q <= (idx_q == '0);
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_q <= 1'b0;
		end else if (ctl.load) begin
			sign_q <= neg;
		end else if (ctl.emit) begin
			sign_q <= 1'b0;
		end
	end

	assign sts.conv_done = (cnt_q == '1);
	assign sts.last = last_q;
	assign char_code = char_q;
	assign last = last_q;

endmodule

>>> src/itad_ctrl.sv
// Controller of the integer to ASCII text converter.
// Sequences accept, BCD conversion, index setup and character delivery.
// Depends on itad_pkg.
module itad_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_hex,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output itad_pkg::itad_ctl_t ctl,
	input  itad_pkg::itad_sts_t sts
);
	import itad_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_PREP = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_SEND = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_SEND);

	always_comb begin
		ctl.load = (state_q == S_IDLE) && in_valid;
		ctl.shift = (state_q == S_CONV);
		ctl.set_idx = (state_q == S_PREP);
		ctl.emit = (state_q == S_LOAD) ||
			((state_q == S_SEND) && out_ready && !sts.last);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = (in_hex == MODE_HEX) ? S_PREP : S_CONV;
				end
			end
			S_CONV: begin
				if (sts.conv_done) begin
					state_nx = S_PREP;
				end
			end
			S_PREP: state_nx = S_LOAD;
			S_LOAD: state_nx = S_SEND;
			S_SEND: begin
				if (out_ready && sts.last) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("Input accepted while a character is pending.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("Ready stayed high after a transaction.");

	a_conv_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && sts.conv_done) |=> (state_q == S_PREP))
		else $error("Conversion did not end after the last shift.");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && sts.last) |=> in_ready)
		else $error("Block did not return to idle after the final character.");

endmodule

>>> src/int_to_ascii_dec_hex.sv
// Integer to ASCII text converter, top level. Depends on itad_pkg, itad_if,
// itad_ctrl and itad_dp.
//
// Each input transaction carries a 32-bit word and a mode; the block returns its
// text one character per output transaction, most significant digit first, with
// last set on the final character. Decimal mode prints the word as signed with a
// leading minus and no leading zeros; hex mode prints lowercase digits padded to
// HEX_DIGITS. One word is converted at a time. A decimal word passes through an
// accept state, the shift-and-add steps of the binary-to-BCD register and the
// setup states S_PREP and S_LOAD, then delivers one character per cycle while the
// output is ready; a hex word skips the shift-and-add steps. Back pressure on the
// output stalls delivery.
module int_to_ascii_dec_hex #(
	parameter int HEX_DIGITS = 8
) (
	input logic         clk,
	input logic         arst_n,
	itad_in_if.sink     in_ch,
	itad_out_if.source  out_ch
);
	import itad_pkg::*;

	localparam int MAX_IDX = (HEX_DIGITS > NUM_DIG) ? HEX_DIGITS : NUM_DIG;
	localparam int IDX_W = $clog2(MAX_IDX);

	itad_ctl_t ctl;
	itad_sts_t sts;

	itad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_hex    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	itad_dp #(
		.HEX_DIGITS (HEX_DIGITS),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_cmd    (in_ch.cmd),
		.in_value  (in_ch.value),
		.char_code (out_ch.char_code),
		.last      (out_ch.last)
	);

endmodule

>>> sim/int_to_ascii_dec_hex_tb.sv
// Testbench for int_to_ascii_dec_hex: drives words in both modes and checks every
// character against a directed table or a predictor of the decimal and hex text, under idling and stalls.
// Depends on itad_pkg, itad_if and the int_to_ascii_dec_hex RTL.
`timescale 1ns / 100ps

module int_to_ascii_dec_hex_tb;
	import itad_pkg::*;

	localparam int HEX_DIGITS = 8;
	localparam int N_DIR = 22;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 60;
	localparam logic [7:0] CH_ZERO = "0";
	localparam logic [7:0] CH_A = "a";

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} text_char_t;

	typedef struct {
		logic        mode;
		logic [31:0] word;
		string       text;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	itad_in_if  in_ch();
	itad_out_if out_ch();

	text_char_t text_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int n_words = 0;
	int n_dec = 0;
	int n_hex = 0;
	int n_chars = 0;
	int n_errors = 0;

	dir_row_t dir_rows [N_DIR] = '{
		'{MODE_DEC, 32'h0000_0000, "0"},
		'{MODE_DEC, 32'h0000_0001, "1"},
		'{MODE_DEC, 32'hFFFF_FFFF, "-1"},
		'{MODE_DEC, 32'h7FFF_FFFF, "2147483647"},
		'{MODE_DEC, 32'h8000_0000, "-2147483648"},
		'{MODE_DEC, 32'h8000_0001, "-2147483647"},
		'{MODE_DEC, 32'd9, "9"},
		'{MODE_DEC, 32'd10, "10"},
		'{MODE_DEC, 32'd1000000000, "1000000000"},
		'{MODE_DEC, 32'd999999999, "999999999"},
		'{MODE_DEC, 32'hFFFF_FFF6, "-10"},
		'{MODE_DEC, 32'd12345, ""},
		'{MODE_DEC, 32'h5A5A_5A5A, ""},
		'{MODE_DEC, 32'hA5A5_A5A5, ""},
		'{MODE_HEX, 32'h0000_0000, "00000000"},
		'{MODE_HEX, 32'hFFFF_FFFF, "ffffffff"},
		'{MODE_HEX, 32'h0000_0001, "00000001"},
		'{MODE_HEX, 32'h8000_0000, "80000000"},
		'{MODE_HEX, 32'h0123_ABCD, "0123abcd"},
		'{MODE_HEX, 32'hDEAD_BEEF, ""},
		'{MODE_HEX, 32'h89AB_CDEF, ""},
		'{MODE_HEX, 32'h7654_3210, ""}
	};

	int_to_ascii_dec_hex #(
		.HEX_DIGITS(HEX_DIGITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queues the characters of one word, most significant digit first.
	function automatic void predict_text(input logic mode, input logic [31:0] word);
		logic [3:0]  rev [0:19];
		logic [31:0] mag;
		logic        neg;
		int          n;
		int          total;
		int          k;
		n = 0;
		neg = 1'b0;
		if (mode == MODE_DEC) begin
			neg = word[31];
			mag = neg ? 32'd0 - word : word;
			do begin
				rev[n] = 4'(mag % 32'd10);
				mag = mag / 32'd10;
				n++;
			end while (mag != 0);
		end else begin
			mag = word;
			do begin
				rev[n] = mag[3:0];
				mag = mag >> 4;
				n++;
			end while (mag != 0);
			while (n < HEX_DIGITS) begin
				rev[n] = 4'd0;
				n++;
			end
		end
		total = n + (neg ? 1 : 0);
		if (neg) begin
			text_due.push_back('{char_code: MINUS_CODE, last: total == 1});
		end
		for (k = n - 1; k >= 0; k--) begin
			text_due.push_back('{
				char_code: (rev[k] < 4'd10) ? CH_ZERO + 8'(rev[k]) : CH_A + 8'(rev[k]) - 8'd10,
				last: k == 0
			});
		end
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] pow;
		int          kind;
		int          k;
		kind = $urandom_range(0, 5);
		case (kind)
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom_range(0, 20);
			end
			2: begin
				return 32'd0 - 32'($urandom_range(1, 20));
			end
			3: begin
				pow = 32'd1;
				for (k = $urandom_range(0, 9); k > 0; k--) begin
					pow = pow * 32'd10;
				end
				pow = pow + 32'($urandom_range(0, 2)) - 32'd1;
				return ($urandom_range(0, 1) != 0) ? 32'd0 - pow : pow;
			end
			4: begin
				return $urandom >> $urandom_range(0, 31);
			end
			default: begin
				return (($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF)
					+ 32'($urandom_range(0, 4)) - 32'd2;
			end
		endcase
	endfunction

	task automatic send_item(input logic mode, input logic [31:0] word, input string text);
		int k;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= mode;
		in_ch.value <= word;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		if (text.len() == 0) begin
			predict_text(mode, word);
		end else begin
			for (k = 0; k < text.len(); k++) begin
				text_due.push_back('{char_code: 8'(text[k]), last: k == text.len() - 1});
			end
		end
		n_words++;
		if (mode == MODE_DEC) begin
			n_dec++;
		end else begin
			n_hex++;
		end
	endtask

	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			send_item(logic'($urandom_range(0, 1)), random_word(), "");
		end
	endtask

	initial begin : receiver
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_chars
		text_char_t due;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (text_due.size() == 0) begin
				$display("%0t: unexpected character, expected none, actual 0x%02h last %0b",
					$time, out_ch.char_code, out_ch.last);
				n_errors++;
			end else begin
				due = text_due.pop_front();
				n_chars++;
				if (out_ch.char_code !== due.char_code) begin
					$display("%0t: char_code mismatch, expected 0x%02h, actual 0x%02h",
						$time, due.char_code, out_ch.char_code);
					n_errors++;
				end
				if (out_ch.last !== due.last) begin
					$display("%0t: last mismatch, expected %0b, actual %0b",
						$time, due.last, out_ch.last);
					n_errors++;
				end
			end
		end
	end

	initial begin
		in_ch.valid <= 1'b0;
		in_ch.cmd <= MODE_DEC;
		in_ch.value <= 32'd0;
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_item(dir_rows[i].mode, dir_rows[i].word, dir_rows[i].text);
		end

		// The long receiver hold fills the block while words keep being offered.
		run_random(10, 0, 0);
		hold_reqs++;
		run_random(40, 0, 0);
		run_random(45, 77, 0);
		run_random(45, 0, 77);
		run_random(50, 24, 24);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (text_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d words (%0d decimal, %0d hex) into %0d checked characters,",
			n_words, n_dec, n_hex, n_chars);
		$display("across free-running, sender-idle, receiver-stall and long-hold phases.");
		if (n_errors == 0 && text_due.size() == 0) begin
			$display("int_to_ascii_dec_hex test passed");
		end else begin
			$display("int_to_ascii_dec_hex test failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("int_to_ascii_dec_hex test failed");
		$finish;
	end

endmodule
